// File: hw/rtl/rrpg_pkg.sv
// ----------------------------------------------------------------------------
// rrpg_pkg
// Shared types and codes for the rounded rectangle path generator.
// ----------------------------------------------------------------------------
package rrpg_pkg;

  localparam int COORD_W             = 32;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int IN_DATA_W           = 6 * COORD_W;
  localparam int OUT_DATA_W          = 6 * COORD_W;
  localparam int KIND_W              = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [KIND_W-1:0]         seg_kind_t;

  localparam seg_kind_t KIND_MOVE  = 3'd0;
  localparam seg_kind_t KIND_LINE  = 3'd1;
  localparam seg_kind_t KIND_CURVE = 3'd2;
  localparam seg_kind_t KIND_CLOSE = 3'd3;
  localparam seg_kind_t KIND_EMPTY = 3'd4;

endpackage

// File: hw/rtl/rounded_rect_path_generator.sv
// ----------------------------------------------------------------------------
// rounded_rect_path_generator
// Turns one rectangle with corner radii into a stream of path segments.
// ----------------------------------------------------------------------------
// Input channel (in_*): one rectangle per item, six signed fixed point words.
// Output channel (out_*): one path segment per item; tuser is the segment
// kind, tlast marks the final segment of a rectangle.
// A rectangle yields 1 segment when empty, 6 for square corners and 6 to 10
// for rounded corners (straight edges only where the radius leaves room).
// The first segment passes the input register, clamp and multiply register,
// geometry register and output register in that order. Throughput is one
// segment per cycle while the receiver accepts: a rectangle occupies the
// segment sequencer until its last segment is loaded, and the next
// rectangle starts in the cycle after the last segment of the one before.
// Up to two more rectangles wait in the input and multiply registers.
// Reset (rst_n low, synchronous) empties every stage; out_tvalid drops.
// When the receiver stalls, the output register holds its segment, the
// sequencer holds, and in_tready falls once the front stages are full.
// ----------------------------------------------------------------------------
module rounded_rect_path_generator #(
  parameter int COORD_FRAC_BITS = rrpg_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // rect_x, rect_y, rect_width, rect_height, radius_x, radius_y (lowest first)
  input  logic [rrpg_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y (lowest first)
  output logic [rrpg_pkg::OUT_DATA_W-1:0]  out_tdata,
  // segment_kind
  output logic [rrpg_pkg::KIND_W-1:0]      out_tuser,
  output logic                             out_tlast
);
  import rrpg_pkg::*;

  localparam int PW = COORD_W + COORD_FRAC_BITS + 1;
  localparam longint KCOEF_L = (223 * (longint'(1) << COORD_FRAC_BITS) + 250) / 500;
  localparam logic signed [COORD_FRAC_BITS:0] KCOEF = KCOEF_L[COORD_FRAC_BITS:0];
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (COORD_FRAC_BITS - 1);

  localparam logic [1:0] MODE_EMPTY  = 2'd0;
  localparam logic [1:0] MODE_SQUARE = 2'd1;
  localparam logic [1:0] MODE_ROUND  = 2'd2;

  // Segment slots of a rounded outline
  localparam logic [3:0] SL_MOVE   = 4'd0;
  localparam logic [3:0] SL_CRV_TL = 4'd1;
  localparam logic [3:0] SL_LN_L   = 4'd2;
  localparam logic [3:0] SL_CRV_BL = 4'd3;
  localparam logic [3:0] SL_LN_B   = 4'd4;
  localparam logic [3:0] SL_CRV_BR = 4'd5;
  localparam logic [3:0] SL_LN_R   = 4'd6;
  localparam logic [3:0] SL_CRV_TR = 4'd7;
  localparam logic [3:0] SL_LN_T   = 4'd8;
  localparam logic [3:0] SL_CLOSE  = 4'd9;
  // Segment slots of a square outline
  localparam logic [3:0] SQ_MOVE   = 4'd0;
  localparam logic [3:0] SQ_LN_L   = 4'd1;
  localparam logic [3:0] SQ_LN_B   = 4'd2;
  localparam logic [3:0] SQ_LN_R   = 4'd3;
  localparam logic [3:0] SQ_LN_T   = 4'd4;

  // ---------------- stage A: input register ----------------
  logic   a_vld_r, a_vld_nxt;
  coord_t a_x_r, a_y_r, a_w_r, a_h_r, a_rx_r, a_ry_r;

  // ---------------- stage B: clamp and multiply ----------------
  logic                 b_vld_r, b_vld_nxt;
  logic [1:0]           b_mode_r;
  logic                 b_line_x_r, b_line_y_r;
  coord_t               b_x_r, b_y_r, b_w_r, b_h_r, b_rx_r, b_ry_r;
  logic signed [PW-1:0] b_px_r, b_py_r;

  // ---------------- stage G: segment sequencer ----------------
  logic       g_vld_r, g_vld_nxt;
  logic [1:0] g_mode_r;
  logic       g_line_x_r, g_line_y_r;
  logic [3:0] g_slot_r;
  coord_t     g_x_r, g_y_r, g_xw_r, g_yh_r, g_rx_r, g_ry_r, g_kx_r, g_ky_r;

  // ---------------- output register ----------------
  logic      out_vld_r, out_vld_nxt;
  coord_t    o_c1x_r, o_c1y_r, o_c2x_r, o_c2y_r, o_ex_r, o_ey_r;
  seg_kind_t o_kind_r;
  logic      o_last_r;

  // Handshake between stages
  logic in_acc, out_load, g_done, g_take, b_take;
  logic seg_last;

  assign out_load  = g_vld_r && (!out_vld_r || out_tready);
  assign g_done    = out_load && seg_last;
  assign g_take    = b_vld_r && (!g_vld_r || g_done);
  assign b_take    = a_vld_r && (!b_vld_r || g_take);
  assign in_tready = !a_vld_r || b_take;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- A -> B logic ----------------
  logic                 a_empty, a_round;
  logic signed [32:0]   a_rx2, a_ry2, a_w33, a_h33;
  logic                 a_line_x, a_line_y;
  coord_t               a_rxc, a_ryc;
  logic signed [PW-1:0] a_px, a_py;

  assign a_empty  = (a_w_r <= 0) || (a_h_r <= 0);
  assign a_round  = (a_rx_r != 0) && (a_ry_r != 0);
  assign a_rx2    = {a_rx_r, 1'b0};
  assign a_ry2    = {a_ry_r, 1'b0};
  assign a_w33    = {a_w_r[COORD_W-1], a_w_r};
  assign a_h33    = {a_h_r[COORD_W-1], a_h_r};
  assign a_line_x = a_rx2 < a_w33;
  assign a_line_y = a_ry2 < a_h33;
  // Clamp a radius to half its side; only reached for a positive side
  assign a_rxc    = (a_rx2 > a_w33) ? (a_w_r >>> 1) : a_rx_r;
  assign a_ryc    = (a_ry2 > a_h33) ? (a_h_r >>> 1) : a_ry_r;
  assign a_px     = a_rxc * KCOEF;
  assign a_py     = a_ryc * KCOEF;

  // ---------------- B -> G logic ----------------
  logic signed [PW-1:0] b_kx_sh, b_ky_sh;
  coord_t               b_xw, b_yh;

  // Round to nearest, halves up: add half and floor
  assign b_kx_sh = (b_px_r + RND) >>> COORD_FRAC_BITS;
  assign b_ky_sh = (b_py_r + RND) >>> COORD_FRAC_BITS;
  assign b_xw    = b_x_r + b_w_r;
  assign b_yh    = b_y_r + b_h_r;

  // ---------------- segment generation ----------------
  seg_kind_t  seg_kind;
  coord_t     seg_c1x, seg_c1y, seg_c2x, seg_c2y, seg_ex, seg_ey;
  logic [3:0] slot_inc, slot_nxt;
  logic       skip_slot;

  assign slot_inc  = g_slot_r + 4'd1;
  assign skip_slot = (((slot_inc == SL_LN_L) || (slot_inc == SL_LN_R)) && !g_line_y_r) ||
                     (((slot_inc == SL_LN_B) || (slot_inc == SL_LN_T)) && !g_line_x_r);
  assign slot_nxt  = (g_mode_r == MODE_ROUND && skip_slot) ? (g_slot_r + 4'd2) : slot_inc;

  always_comb begin
    seg_kind = KIND_EMPTY;
    seg_c1x  = '0;
    seg_c1y  = '0;
    seg_c2x  = '0;
    seg_c2y  = '0;
    seg_ex   = '0;
    seg_ey   = '0;
    seg_last = 1'b0;
    unique case (g_mode_r)
      MODE_SQUARE: begin
        unique case (g_slot_r)
          SQ_MOVE: begin
            seg_kind = KIND_MOVE;
            seg_ex   = g_x_r;
            seg_ey   = g_y_r;
          end
          SQ_LN_L: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_x_r;
            seg_ey   = g_yh_r;
          end
          SQ_LN_B: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_xw_r;
            seg_ey   = g_yh_r;
          end
          SQ_LN_R: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_xw_r;
            seg_ey   = g_y_r;
          end
          SQ_LN_T: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_x_r;
            seg_ey   = g_y_r;
          end
          default: begin
            seg_kind = KIND_CLOSE;
            seg_ex   = g_x_r;
            seg_ey   = g_y_r;
            seg_last = 1'b1;
          end
        endcase
      end
      MODE_ROUND: begin
        unique case (g_slot_r)
          SL_MOVE: begin
            seg_kind = KIND_MOVE;
            seg_ex   = g_x_r + g_rx_r;
            seg_ey   = g_y_r;
          end
          SL_CRV_TL: begin
            seg_kind = KIND_CURVE;
            seg_c1x  = g_x_r + g_kx_r;
            seg_c1y  = g_y_r;
            seg_c2x  = g_x_r;
            seg_c2y  = g_y_r + g_ky_r;
            seg_ex   = g_x_r;
            seg_ey   = g_y_r + g_ry_r;
          end
          SL_LN_L: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_x_r;
            seg_ey   = g_yh_r - g_ry_r;
          end
          SL_CRV_BL: begin
            seg_kind = KIND_CURVE;
            seg_c1x  = g_x_r;
            seg_c1y  = g_yh_r - g_ky_r;
            seg_c2x  = g_x_r + g_kx_r;
            seg_c2y  = g_yh_r;
            seg_ex   = g_x_r + g_rx_r;
            seg_ey   = g_yh_r;
          end
          SL_LN_B: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_xw_r - g_rx_r;
            seg_ey   = g_yh_r;
          end
          SL_CRV_BR: begin
            seg_kind = KIND_CURVE;
            seg_c1x  = g_xw_r - g_kx_r;
            seg_c1y  = g_yh_r;
            seg_c2x  = g_xw_r;
            seg_c2y  = g_yh_r - g_ky_r;
            seg_ex   = g_xw_r;
            seg_ey   = g_yh_r - g_ry_r;
          end
          SL_LN_R: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_xw_r;
            seg_ey   = g_y_r + g_ry_r;
          end
          SL_CRV_TR: begin
            seg_kind = KIND_CURVE;
            seg_c1x  = g_xw_r;
            seg_c1y  = g_y_r + g_ky_r;
            seg_c2x  = g_xw_r - g_kx_r;
            seg_c2y  = g_y_r;
            seg_ex   = g_xw_r - g_rx_r;
            seg_ey   = g_y_r;
          end
          SL_LN_T: begin
            seg_kind = KIND_LINE;
            seg_ex   = g_x_r + g_rx_r;
            seg_ey   = g_y_r;
          end
          default: begin
            seg_kind = KIND_CLOSE;
            seg_ex   = g_x_r + g_rx_r;
            seg_ey   = g_y_r;
            seg_last = 1'b1;
          end
        endcase
      end
      default: begin
        seg_kind = KIND_EMPTY;
        seg_last = 1'b1;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_comb begin
    a_vld_nxt   = in_acc ? 1'b1 : (b_take ? 1'b0 : a_vld_r);
    b_vld_nxt   = b_take ? 1'b1 : (g_take ? 1'b0 : b_vld_r);
    g_vld_nxt   = g_take ? 1'b1 : (g_done ? 1'b0 : g_vld_r);
    out_vld_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      g_slot_r  <= '0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      g_vld_r   <= g_vld_nxt;
      out_vld_r <= out_vld_nxt;
      // Restart the slot count on a new rectangle, else advance per segment
      if (g_take) begin
        g_slot_r <= '0;
      end else if (out_load) begin
        g_slot_r <= slot_nxt;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_x_r  <= in_tdata[0*COORD_W +: COORD_W];
      a_y_r  <= in_tdata[1*COORD_W +: COORD_W];
      a_w_r  <= in_tdata[2*COORD_W +: COORD_W];
      a_h_r  <= in_tdata[3*COORD_W +: COORD_W];
      a_rx_r <= in_tdata[4*COORD_W +: COORD_W];
      a_ry_r <= in_tdata[5*COORD_W +: COORD_W];
    end
    if (b_take) begin
      b_mode_r   <= a_empty ? MODE_EMPTY : (a_round ? MODE_ROUND : MODE_SQUARE);
      b_line_x_r <= a_line_x;
      b_line_y_r <= a_line_y;
      b_x_r      <= a_x_r;
      b_y_r      <= a_y_r;
      b_w_r      <= a_w_r;
      b_h_r      <= a_h_r;
      b_rx_r     <= a_rxc;
      b_ry_r     <= a_ryc;
      b_px_r     <= a_px;
      b_py_r     <= a_py;
    end
    if (g_take) begin
      g_mode_r   <= b_mode_r;
      g_line_x_r <= b_line_x_r;
      g_line_y_r <= b_line_y_r;
      g_x_r      <= b_x_r;
      g_y_r      <= b_y_r;
      g_xw_r     <= b_xw;
      g_yh_r     <= b_yh;
      g_rx_r     <= b_rx_r;
      g_ry_r     <= b_ry_r;
      g_kx_r     <= b_kx_sh[COORD_W-1:0];
      g_ky_r     <= b_ky_sh[COORD_W-1:0];
    end
    if (out_load) begin
      o_kind_r <= seg_kind;
      o_c1x_r  <= seg_c1x;
      o_c1y_r  <= seg_c1y;
      o_c2x_r  <= seg_c2x;
      o_c2y_r  <= seg_c2y;
      o_ex_r   <= seg_ex;
      o_ey_r   <= seg_ey;
      o_last_r <= seg_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {o_ey_r, o_ex_r, o_c2y_r, o_c2x_r, o_c1y_r, o_c1x_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  // ---------------- assertions ----------------
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == KIND_EMPTY) || (out_tuser == KIND_CLOSE))
    else $error("last segment is neither closepath nor empty");

  a_end_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_EMPTY) || (out_tuser == KIND_CLOSE)) |-> out_tlast)
    else $error("closepath or empty segment without tlast");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_vld_r |-> (g_slot_r <= SL_CLOSE))
    else $error("segment slot past closepath");

  a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    g_take |-> !g_vld_r || (out_load && seg_last))
    else $error("sequencer reloaded while a rectangle is unfinished");

endmodule
